### rtl/core/fadeseq_pkg.sv
// Shared item codes, phase codes, register indexes and controller command bundle
// for the RGB565 ease-out fade sequencer. No dependencies.
package fadeseq_pkg;

	localparam int ColorW = 16;
	localparam int AlphaW = 8;
	localparam int TimeW  = 16;
	localparam int KindW  = 2;
	localparam int PhaseW = 2;
	localparam int CfgIdxW = 2;
	// Quotient bits of the alpha divide; alpha never exceeds 255.
	localparam int DivSteps = 8;

	// Item kinds
	localparam logic [KindW-1:0] KIND_RESTART = 2'd0;
	localparam logic [KindW-1:0] KIND_TICK    = 2'd1;
	localparam logic [KindW-1:0] KIND_PIXEL   = 2'd2;

	// Sequence phases
	localparam logic [PhaseW-1:0] PH_FADE_IN  = 2'd0;
	localparam logic [PhaseW-1:0] PH_HOLD     = 2'd1;
	localparam logic [PhaseW-1:0] PH_FADE_OUT = 2'd2;
	localparam logic [PhaseW-1:0] PH_DONE     = 2'd3;

	// Register indexes
	localparam logic [CfgIdxW-1:0] CFG_FADE_IN  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_HOLD     = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_FADE_OUT = 2'd2;

	localparam logic [TimeW-1:0] FADE_IN_RST  = 16'd600;
	localparam logic [TimeW-1:0] HOLD_RST     = 16'd1400;
	localparam logic [TimeW-1:0] FADE_OUT_RST = 16'd500;

	localparam logic [AlphaW-1:0] ALPHA_MAX = 8'd255;

	typedef struct packed {
		logic accept;    // item taken this cycle
		logic mul;       // form D*D and el*(2D-el)
		logic prep;      // form dividend and aligned divisor
		logic div_step;  // one quotient bit
		logic finish;    // write eased alpha
		logic load_out;  // load the output register
	} fadeseq_cmd_t;

endpackage

### rtl/core/rgb565_ease_fade_sequencer.sv
// Top level of the RGB565 ease-out fade sequencer: controller plus datapath.
// Depends on fadeseq_pkg, fadeseq_ctrl and fadeseq_dp.
//
// The block plays one fade sequence: fade-in from alpha 0 to 255 with an
// ease-out-quad curve, hold at 255, fade-out to 0, then finished (black).
// Each input beat is a restart, a one-millisecond tick or an RGB565 pixel,
// and each gives exactly one output beat carrying the scaled pixel (zero for
// non-pixels), the alpha and the phase after the beat. Pixels, restarts,
// unused codes and ticks that end a phase, fall in the hold phase or arrive
// after the finish need no divide, so they stream at one beat per cycle
// while the output side keeps up. A tick inside a fade holds off the next
// acceptance while it runs the two multiplies (D*D and el*(2D-el)), forms
// the dividend, runs the restoring divider that produces one alpha bit per
// cycle, and then writes the eased alpha and loads the output register.
// The duration registers sit on a separate write port that is always ready;
// write them only while no beat is in flight.
module rgb565_ease_fade_sequencer import fadeseq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// item channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [KindW-1:0]   kind,
	input  logic [ColorW-1:0]  color,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ColorW-1:0]  scaled_color,
	output logic [AlphaW-1:0]  alpha_now,
	output logic [PhaseW-1:0]  phase_now,
	// register write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [TimeW-1:0]   cfg_data
);

	fadeseq_cmd_t      cmd;
	logic              need_div;
	logic              busy;
	logic [PhaseW-1:0] cur_phase;
	logic [AlphaW-1:0] cur_alpha;

	// Registers take a write in any cycle.
	assign cfg_ready = 1'b1;

	fadeseq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.need_div  (need_div),
		.cmd       (cmd),
		.busy      (busy)
	);

	fadeseq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.kind         (kind),
		.color        (color),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.need_div     (need_div),
		.scaled_color (scaled_color),
		.alpha_now    (alpha_now),
		.phase_now    (phase_now),
		.cur_phase    (cur_phase),
		.cur_alpha    (cur_alpha)
	);

	// Hold phase always runs at full alpha.
	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		cur_phase == PH_HOLD |-> cur_alpha == ALPHA_MAX)
		else $error("hold phase with alpha below full");

	// Finished sequence stays black.
	a_done_black: assert property (@(posedge clk) disable iff (!arst_n)
		cur_phase == PH_DONE |-> cur_alpha == '0)
		else $error("finished phase with nonzero alpha");

	// While the divider runs, the output register stays empty for its result.
	a_busy_empty: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !out_valid)
		else $error("output occupied while alpha divide in flight");

	// A fade tick blocks the input for the cycle after acceptance.
	a_div_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && need_div |=> !in_ready)
		else $error("input accepted during alpha divide");

endmodule

### rtl/core/fadeseq_ctrl.sv
// Controller for the fade sequencer: handshake, output-register occupancy and the
// sequence of multiply, prepare and divide steps. Depends on fadeseq_pkg.
module fadeseq_ctrl import fadeseq_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  logic         need_div,
	output fadeseq_cmd_t cmd,
	output logic         busy
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0] state_q, state_d;
	logic [$clog2(DivSteps)-1:0] cnt_q;
	logic out_valid_q;
	logic accept;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign busy     = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.accept   = accept;
		cmd.mul      = (state_q == ST_MUL);
		cmd.prep     = (state_q == ST_PREP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.finish   = (state_q == ST_FIN);
		cmd.load_out = (accept && !need_div) || (state_q == ST_FIN);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && need_div) state_d = ST_MUL;
			ST_MUL:  state_d = ST_PREP;
			ST_PREP: state_d = ST_DIV;
			ST_DIV:  if (&cnt_q) state_d = ST_FIN;
			ST_FIN:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// advance the quotient bit count only while dividing
			if (state_q == ST_DIV)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

### rtl/core/fadeseq_dp.sv
// Datapath for the fade sequencer: duration registers, phase/time/alpha state,
// eased-alpha multiply and restoring divide, pixel scaler, output register.
// Depends on fadeseq_pkg.
module fadeseq_dp import fadeseq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  fadeseq_cmd_t       cmd,
	input  logic [KindW-1:0]   kind,
	input  logic [ColorW-1:0]  color,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [TimeW-1:0]   cfg_data,
	output logic               need_div,
	output logic [ColorW-1:0]  scaled_color,
	output logic [AlphaW-1:0]  alpha_now,
	output logic [PhaseW-1:0]  phase_now,
	output logic [PhaseW-1:0]  cur_phase,
	output logic [AlphaW-1:0]  cur_alpha
);

	localparam int NumW = 40;  // 255*N + D*D - 1 stays below 256*D*D

	logic [TimeW-1:0]  fade_in_q, hold_q, fade_out_q;
	logic [PhaseW-1:0] phase_q;
	logic [TimeW-1:0]  elapsed_q;
	logic [AlphaW-1:0] alpha_q;

	logic [ColorW-1:0] scaled_q;
	logic [AlphaW-1:0] alpha_out_q;
	logic [PhaseW-1:0] phase_out_q;

	logic [31:0]       dd_q, n_q;
	logic [NumW-1:0]   rem_q, dv_q;
	logic [AlphaW-1:0] quo_q;

	// floor(x/255) for x below 16384
	function automatic logic [7:0] div255(input logic [13:0] x);
		logic [14:0] s;
		s = {1'b0, x} + {9'b0, x[13:8]} + 15'd1;
		return {1'b0, s[14:8]};
	endfunction

	// ---------------- tick decode ----------------
	logic [TimeW-1:0]  el_inc, len;
	logic              ends;
	logic [PhaseW-1:0] ph_tk;
	logic [TimeW-1:0]  el_tk;
	logic [AlphaW-1:0] al_tk;
	logic              tk_div;

	assign el_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		unique case (phase_q)
			PH_FADE_IN:  len = fade_in_q;
			PH_HOLD:     len = hold_q;
			PH_FADE_OUT: len = fade_out_q;
			default:     len = '1;
		endcase
	end

	assign ends = (el_inc >= len);

	always_comb begin
		ph_tk  = phase_q;
		el_tk  = el_inc;
		al_tk  = alpha_q;
		tk_div = 1'b0;
		unique case (phase_q)
			PH_FADE_IN: begin
				if (ends) begin
					ph_tk = PH_HOLD;
					el_tk = '0;
					al_tk = ALPHA_MAX;
				end else begin
					tk_div = 1'b1;
				end
			end
			PH_HOLD: begin
				al_tk = ALPHA_MAX;
				if (ends) begin
					ph_tk = PH_FADE_OUT;
					el_tk = '0;
				end
			end
			PH_FADE_OUT: begin
				if (ends) begin
					ph_tk = PH_DONE;
					el_tk = '0;
					al_tk = '0;
				end else begin
					tk_div = 1'b1;
				end
			end
			default: el_tk = elapsed_q;  // finished: a tick changes nothing
		endcase
	end

	assign need_div = (kind == KIND_TICK) && tk_div;

	// ---------------- per-item next state ----------------
	logic [PhaseW-1:0] ph_nx;
	logic [TimeW-1:0]  el_nx;
	logic [AlphaW-1:0] al_nx;

	always_comb begin
		ph_nx = phase_q;
		el_nx = elapsed_q;
		al_nx = alpha_q;
		case (kind)
			KIND_RESTART: begin
				ph_nx = PH_FADE_IN;
				el_nx = '0;
				al_nx = '0;
			end
			KIND_TICK: begin
				ph_nx = ph_tk;
				el_nx = el_tk;
				al_nx = al_tk;
			end
			default: ;
		endcase
	end

	// ---------------- pixel scaler ----------------
	logic [12:0] xr, xb;
	logic [13:0] xg;
	logic [7:0]  qr, qg, qb;
	logic [ColorW-1:0] pix;

	assign xr  = 13'(color[15:11]) * 13'(alpha_q);
	assign xg  = 14'(color[10:5]) * 14'(alpha_q);
	assign xb  = 13'(color[4:0]) * 13'(alpha_q);
	assign qr  = div255({1'b0, xr});
	assign qg  = div255(xg);
	assign qb  = div255({1'b0, xb});
	assign pix = {qr[4:0], qg[5:0], qb[4:0]};

	// ---------------- eased alpha ----------------
	logic            is_out;
	logic [TimeW-1:0] d_sel;
	logic [16:0]     span;
	logic [31:0]     dd_w;
	logic [31:0]     n_w;
	logic [NumW-1:0] num_w, bias_w;
	logic [AlphaW-1:0] al_fin;

	assign is_out = (phase_q == PH_FADE_OUT);
	assign d_sel  = is_out ? fade_out_q : fade_in_q;
	assign span   = {d_sel, 1'b0} - {1'b0, elapsed_q};
	assign dd_w   = 32'(d_sel) * 32'(d_sel);
	// el < D, so el*(2D-el) stays below D*D and fits 32 bits
	assign n_w    = 32'(elapsed_q) * 32'(span);
	// 255*N, plus D*D-1 for the ceiling used on the way down
	assign bias_w = is_out ? {8'b0, dd_q - 32'd1} : '0;
	assign num_w  = {n_q, 8'b0} - {8'b0, n_q} + bias_w;
	assign al_fin = is_out ? ALPHA_MAX - quo_q : quo_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			dd_q <= dd_w;
			n_q  <= n_w;
		end
		if (cmd.prep) begin
			rem_q <= num_w;
			dv_q  <= {1'b0, dd_q, 7'b0};
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (rem_q >= dv_q) begin
				rem_q <= rem_q - dv_q;
				quo_q <= {quo_q[AlphaW-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[AlphaW-2:0], 1'b0};
			end
			dv_q <= dv_q >> 1;
		end
		if (cmd.load_out) begin
			if (cmd.finish) begin
				scaled_q    <= '0;
				alpha_out_q <= al_fin;
				phase_out_q <= phase_q;
			end else begin
				scaled_q    <= (kind == KIND_PIXEL) ? pix : '0;
				alpha_out_q <= al_nx;
				phase_out_q <= ph_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_in_q  <= FADE_IN_RST;
			hold_q     <= HOLD_RST;
			fade_out_q <= FADE_OUT_RST;
			phase_q    <= PH_FADE_IN;
			elapsed_q  <= '0;
			alpha_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FADE_IN:  fade_in_q  <= cfg_data;
					CFG_HOLD:     hold_q     <= cfg_data;
					CFG_FADE_OUT: fade_out_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				phase_q   <= ph_nx;
				elapsed_q <= el_nx;
				// eased fade alpha lands at finish instead
				if (!need_div)
					alpha_q <= al_nx;
			end
			if (cmd.finish)
				alpha_q <= al_fin;
		end
	end

	assign scaled_color = scaled_q;
	assign alpha_now    = alpha_out_q;
	assign phase_now    = phase_out_q;
	assign cur_phase    = phase_q;
	assign cur_alpha    = alpha_q;

endmodule
